// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define BTPL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("btpl checker: same-cycle property failed");

// property that must hold in the cycle after its trigger
`define BTPL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpl checker: next-cycle property failed");

// property that must hold in the cycle after reset is seen
`define BTPL_ASSERT_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("btpl checker: post-reset property failed");

`endif

// ===== hw/rtl/btpl_pkg.sv =====
// shared constants, node format and controller/datapath command types
`timescale 1ns / 1ps
`default_nettype none
package btpl_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = $clog2(NODE_COUNT + 1);
  localparam int PORT_BITS  = 8;
  localparam int RES_PORT_W = 8;
  localparam int ADDR_BITS  = 32;
  localparam int DEPTH_W    = 6;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_LOOKUP   = 1'b1;
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [NODE_W-1:0] node_idx_t;

  localparam node_idx_t NO_CHILD = '0;

  typedef struct packed {
    node_idx_t            child1;
    node_idx_t            child0;
    logic                 valid;
    logic [PORT_BITS-1:0] port;
  } node_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic write_final;
    logic link;
    logic grow;
    logic load_res;
    logic refuse;
  } btpl_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic step;
    logic at_limit;
    logic pool_full;
  } btpl_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/btpl_if.sv =====
// valid/ready channel interfaces for request and result words
`timescale 1ns / 1ps
`default_nettype none
interface btpl_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] ip_address;
  logic [5:0]  prefix_length;
  logic [7:0]  port_number;

  modport source (output valid, output op, output ip_address, output prefix_length,
                  output port_number, input ready);
  modport sink (input valid, input op, input ip_address, input prefix_length,
                input port_number, output ready);
endinterface

interface btpl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_port;
  logic       status;

  modport source (output valid, output result_port, output status, input ready);
  modport sink (input valid, input result_port, input status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/btpl_datapath.sv =====
// node memory, root node, walk registers, allocation counter and result register
`timescale 1ns / 1ps
`default_nettype none
module btpl_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire btpl_pkg::btpl_cmd_t   cmd,
  input  wire logic                  in_op,
  input  wire logic [31:0]           in_ip_address,
  input  wire logic [5:0]            in_prefix_length,
  input  wire logic [7:0]            in_port_number,
  output btpl_pkg::btpl_stat_t       stat,
  output logic [7:0]                 out_result_port,
  output logic                       out_status
);

  // node zero sits in flops so that it reads empty straight after reset
  btpl_pkg::node_t     root_r;
  btpl_pkg::node_t     node_mem_r [btpl_pkg::NODE_COUNT];
  btpl_pkg::node_t     mem_q_r;
  logic                rd_root_r;
  logic [btpl_pkg::USED_W-1:0]    used_r;

  logic                           op_r;
  logic [btpl_pkg::ADDR_BITS-1:0] addr_sh_r;
  logic [btpl_pkg::DEPTH_W-1:0]   len_r;
  logic [7:0]                     port_r;
  logic [btpl_pkg::DEPTH_W-1:0]   depth_r;
  btpl_pkg::node_idx_t            cur_idx_r;
  logic [btpl_pkg::PORT_BITS-1:0] best_r;
  logic [btpl_pkg::RES_PORT_W-1:0] res_port_r;
  logic                           res_status_r;

  btpl_pkg::node_t                node_v;
  logic                           bit_v;
  btpl_pkg::node_idx_t            child_v;
  btpl_pkg::node_idx_t            new_idx;
  logic [btpl_pkg::DEPTH_W-1:0]   limit_v;
  logic [btpl_pkg::DEPTH_W-1:0]   missing_v;
  logic [btpl_pkg::USED_W:0]      need_v;
  logic [btpl_pkg::PORT_BITS-1:0] best_nxt;
  logic                           at_limit;
  logic                           wr_en;
  btpl_pkg::node_idx_t            wr_addr;
  btpl_pkg::node_t                wr_data;
  logic [btpl_pkg::DEPTH_W-1:0]   len_clamped;

  assign node_v   = rd_root_r ? root_r : mem_q_r;
  assign bit_v    = addr_sh_r[btpl_pkg::ADDR_BITS-1];
  assign child_v  = bit_v ? node_v.child1 : node_v.child0;
  assign new_idx  = used_r[btpl_pkg::NODE_W-1:0];
  assign limit_v  = (op_r == btpl_pkg::OP_LOOKUP) ?
                    btpl_pkg::DEPTH_W'(btpl_pkg::ADDR_BITS) : len_r;
  assign at_limit = (depth_r == limit_v);
  assign best_nxt = node_v.valid ? node_v.port : best_r;

  // nodes still to allocate once the walk has met a missing child
  assign missing_v = len_r - depth_r;
  assign need_v    = {1'b0, used_r} + (btpl_pkg::USED_W + 1)'(missing_v);

  assign len_clamped = (in_prefix_length > btpl_pkg::DEPTH_W'(btpl_pkg::ADDR_BITS)) ?
                       btpl_pkg::DEPTH_W'(btpl_pkg::ADDR_BITS) : in_prefix_length;

  assign stat.is_lookup = (op_r == btpl_pkg::OP_LOOKUP);
  assign stat.at_limit  = at_limit;
  assign stat.step      = !at_limit && (child_v != btpl_pkg::NO_CHILD);
  assign stat.pool_full = need_v > (btpl_pkg::USED_W + 1)'(btpl_pkg::NODE_COUNT);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = new_idx;
    wr_data = '0;
    priority if (cmd.write_final) begin
      wr_en         = 1'b1;
      wr_addr       = cur_idx_r;
      wr_data       = node_v;
      wr_data.valid = 1'b1;
      wr_data.port  = btpl_pkg::PORT_BITS'(port_r);
    end else if (cmd.link) begin
      wr_en   = 1'b1;
      wr_addr = cur_idx_r;
      wr_data = node_v;
      if (bit_v) begin
        wr_data.child1 = new_idx;
      end else begin
        wr_data.child0 = new_idx;
      end
    end else if (cmd.grow) begin
      wr_en   = 1'b1;
      wr_addr = new_idx;
      if (at_limit) begin
        wr_data.valid = 1'b1;
        wr_data.port  = btpl_pkg::PORT_BITS'(port_r);
      end else if (bit_v) begin
        wr_data.child1 = new_idx + btpl_pkg::NODE_W'(1);
      end else begin
        wr_data.child0 = new_idx + btpl_pkg::NODE_W'(1);
      end
    end else begin
      wr_en = 1'b0;
    end
  end

  // node memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr != btpl_pkg::NO_CHILD)) begin
      node_mem_r[wr_addr] <= wr_data;
    end
    if (cmd.advance) begin
      mem_q_r <= node_mem_r[child_v];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r    <= '0;
      rd_root_r <= 1'b1;
      used_r    <= btpl_pkg::USED_W'(1);
    end else begin
      if (wr_en && (wr_addr == btpl_pkg::NO_CHILD)) begin
        root_r <= wr_data;
      end
      if (cmd.load) begin
        rd_root_r <= 1'b1;
      end else if (cmd.advance) begin
        rd_root_r <= 1'b0;
      end
      if (cmd.grow) begin
        used_r <= used_r + btpl_pkg::USED_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      addr_sh_r <= in_ip_address;
      len_r     <= len_clamped;
      port_r    <= in_port_number;
      depth_r   <= '0;
      cur_idx_r <= btpl_pkg::NO_CHILD;
      best_r    <= '0;
    end else if (cmd.advance || cmd.link || cmd.grow) begin
      depth_r   <= depth_r + btpl_pkg::DEPTH_W'(1);
      addr_sh_r <= {addr_sh_r[btpl_pkg::ADDR_BITS-2:0], 1'b0};
      if (cmd.advance) begin
        cur_idx_r <= child_v;
        best_r    <= best_nxt;
      end
    end
    if (cmd.load_res) begin
      res_port_r   <= (stat.is_lookup && !cmd.refuse) ?
                      btpl_pkg::RES_PORT_W'(best_nxt) : '0;
      res_status_r <= cmd.refuse ? btpl_pkg::STATUS_FULL : btpl_pkg::STATUS_DONE;
    end
  end

  assign out_result_port = res_port_r;
  assign out_status      = res_status_r;

endmodule
`default_nettype wire

// ===== hw/rtl/btpl_ctrl.sv =====
// controller: sequences walk, link and grow steps and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none
module btpl_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire btpl_pkg::btpl_stat_t stat,
  output btpl_pkg::btpl_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_GROW = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   res_free;

  // result register can take a new word this cycle
  assign res_free = !out_valid_r || out_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        priority if (stat.step) begin
          cmd.advance = 1'b1;
        end else if (!stat.is_lookup && !stat.at_limit && !stat.pool_full) begin
          cmd.link  = 1'b1;
          state_nxt = S_GROW;
        end else if (res_free) begin
          cmd.load_res    = 1'b1;
          cmd.refuse      = !stat.is_lookup && !stat.at_limit;
          cmd.write_final = !stat.is_lookup && stat.at_limit;
          state_nxt       = S_IDLE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_GROW: begin
        // the last new node waits until the result word can be loaded
        cmd.grow = !stat.at_limit || res_free;
        if (stat.at_limit && res_free) begin
          cmd.load_res = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== hw/rtl/binary_trie_prefix_lookup_unit.sv =====
// Longest-prefix-match unit for IPv4 over a one-bit-per-level binary trie of 4096
// nodes. Each request word is an insert (prefix, length, port) or a lookup; each
// gives exactly one result word. A lookup walks the trie with one registered read
// of the node memory per trie level matched, at most 32 levels; an insert walks
// the existing levels the same way, with existing plus new levels at most 32, and
// then writes one new node per missing level. The root node is held in flops, so
// the unit is ready at once after reset with no memory clearing. One request is
// in flight at a time; a finished result waits in an output register while the
// next request is taken, and a walk that ends while that word still waits holds
// until it leaves.
`timescale 1ns / 1ps
`default_nettype none
module binary_trie_prefix_lookup_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  btpl_in_if.sink    in_ch,
  btpl_out_if.source out_ch
);

  btpl_pkg::btpl_cmd_t  cmd;
  btpl_pkg::btpl_stat_t stat;

  btpl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  btpl_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_op            (in_ch.op),
    .in_ip_address    (in_ch.ip_address),
    .in_prefix_length (in_ch.prefix_length),
    .in_port_number   (in_ch.port_number),
    .stat             (stat),
    .out_result_port  (out_ch.result_port),
    .out_status       (out_ch.status)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/btpl_checker.sv =====
// port-level checker for the lookup unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module btpl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_result_port,
  input wire logic       out_status
);

  // a stalled result word stays put
  `BTPL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result_port) && $stable(out_status))

  // one request at a time: no second word right after an accepted one
  `BTPL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // a refused insert never reports a port
  `BTPL_ASSERT_SAME(a_full_no_port, out_valid && out_status, out_result_port == 8'd0)

  // nothing to deliver straight out of reset
  `BTPL_ASSERT_RESET(a_reset_quiet, !out_valid)

endmodule

bind binary_trie_prefix_lookup_unit btpl_checker u_btpl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_port (out_ch.result_port),
  .out_status      (out_ch.status)
);
`default_nettype wire

// ===== verif/binary_trie_prefix_lookup_unit_test.sv =====
// self-checking testbench for the binary trie longest-prefix-match unit
`timescale 1ns / 1ps
module binary_trie_prefix_lookup_unit_test;
  import btpl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 120;

  typedef struct {
    logic                  op;
    logic [ADDR_BITS-1:0]  addr;
    logic [DEPTH_W-1:0]    len;
    logic [7:0]            port;
    bit                    after_drain;
  } route_req_t;

  typedef struct {
    logic [RES_PORT_W-1:0] port;
    logic                  status;
  } route_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  btpl_in_if  in_ch ();
  btpl_out_if out_ch ();

  binary_trie_prefix_lookup_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  route_req_t    pending_reqs[$];
  route_result_t awaited_results[$];
  logic [31:0]   known_addr[$];
  int unsigned   known_len[$];

  int words_planned = 0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // trie mirror: children, valid mark and port per node, plus pool fill
  bit [NODE_W-1:0]      kid [NODE_COUNT][2];
  bit                   marked [NODE_COUNT];
  logic [PORT_BITS-1:0] stored_port [NODE_COUNT];
  int unsigned          nodes_taken = 1;

  function automatic logic trie_insert(logic [31:0] addr, logic [5:0] len_in,
                                       logic [7:0] port);
    int unsigned len, depth, node, next, missing;
    logic        b;
    len = (len_in > ADDR_BITS) ? ADDR_BITS : len_in;
    node = 0;
    missing = 0;
    for (depth = 0; depth < len; depth++) begin
      b = addr[31 - depth];
      if (kid[node][b] == NO_CHILD) begin
        missing = len - depth;
        break;
      end
      node = kid[node][b];
    end
    // refused inserts leave the trie untouched
    if (nodes_taken + missing > NODE_COUNT) return STATUS_FULL;
    node = 0;
    for (depth = 0; depth < len; depth++) begin
      b = addr[31 - depth];
      next = kid[node][b];
      if (next == NO_CHILD) begin
        next = nodes_taken;
        nodes_taken++;
        kid[next][0] = NO_CHILD;
        kid[next][1] = NO_CHILD;
        marked[next] = 1'b0;
        stored_port[next] = '0;
        kid[node][b] = node_idx_t'(next);
      end
      node = next;
    end
    marked[node] = 1'b1;
    stored_port[node] = port[PORT_BITS-1:0];
    return STATUS_DONE;
  endfunction

  function automatic logic [RES_PORT_W-1:0] trie_best_port(logic [31:0] addr);
    int unsigned          depth, node;
    logic [PORT_BITS-1:0] best;
    logic                 b;
    node = 0;
    best = '0;
    for (depth = 0; depth <= ADDR_BITS; depth++) begin
      if (marked[node]) best = stored_port[node];
      if (depth == ADDR_BITS) break;
      b = addr[31 - depth];
      if (kid[node][b] == NO_CHILD) break;
      node = kid[node][b];
    end
    return RES_PORT_W'(best);
  endfunction

  function automatic void plan_word(logic op, logic [31:0] addr, logic [5:0] len,
                                    logic [7:0] port, bit after_drain = 1'b0);
    route_req_t r;
    r.op = op;
    r.addr = addr;
    r.len = len;
    r.port = port;
    r.after_drain = after_drain;
    pending_reqs.push_back(r);
    words_planned++;
    if (op == OP_INSERT) begin
      known_addr.push_back(addr);
      known_len.push_back((len > ADDR_BITS) ? ADDR_BITS : len);
    end
  endfunction

  // random address sharing the leading bits of some prefix already planned
  function automatic logic [31:0] addr_under();
    int unsigned pick;
    logic [31:0] mask;
    pick = $urandom_range(0, known_addr.size() - 1);
    mask = ~(32'hFFFF_FFFF >> known_len[pick]);
    return (known_addr[pick] & mask) | ($urandom() & ~mask);
  endfunction

  // sender: bursts of words with random gaps, optional pause for a full drain
  int burst_left = 4;
  int gap_left = 0;

  always @(posedge clk) begin
    route_req_t    nxt;
    route_result_t want;
    logic          offer;
    offer = 1'b0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_INSERT) begin
          want.port = '0;
          want.status = trie_insert(in_ch.ip_address, in_ch.prefix_length,
                                    in_ch.port_number);
        end else begin
          want.port = trie_best_port(in_ch.ip_address);
          want.status = STATUS_DONE;
        end
        awaited_results.push_back(want);
        words_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].after_drain && awaited_results.size() > 0)) begin
          nxt = pending_reqs.pop_front();
          offer = 1'b1;
          in_ch.op <= nxt.op;
          in_ch.ip_address <= nxt.addr;
          in_ch.prefix_length <= nxt.len;
          in_ch.port_number <= nxt.port;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        in_ch.valid <= offer;
      end
    end
  end

  // receiver: stall pattern changes mode now and then, one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  int  stall_mode = 0;
  int  mode_left = 0;
  int  tick = 0;

  always @(posedge clk) begin
    route_result_t want;
    logic          rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with nothing awaited: port %h status %b",
                   $time, out_ch.result_port, out_ch.status);
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.result_port !== want.port) begin
            $display("%0t: result_port mismatch: expected %h actual %h",
                     $time, want.port, out_ch.result_port);
            mismatch_count++;
          end
          if (out_ch.status !== want.status) begin
            $display("%0t: status mismatch: expected %b actual %b",
                     $time, want.status, out_ch.status);
            mismatch_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_OFF_AT) begin
        // long hold-off so the unit backs up and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end else begin
          mode_left--;
        end
        tick++;
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = $urandom_range(0, 1);
          2: rdy = ($urandom_range(0, 5) == 0);
          default: rdy = ((tick % 7) < 3);
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** binary_trie_prefix_lookup_unit: FAILED **");
    $finish;
  end

  initial begin
    int          r;
    logic [5:0]  len;
    logic [31:0] addr;
    int unsigned pick;
    in_ch.valid = 1'b0;
    in_ch.op = OP_INSERT;
    in_ch.ip_address = '0;
    in_ch.prefix_length = '0;
    in_ch.port_number = '0;
    out_ch.ready = 1'b0;

    // directed: empty trie, address extremes, default route, long prefix,
    // out-of-order nesting, re-insert and a zero port
    plan_word(OP_LOOKUP, 32'h0000_0000, 6'd0, 8'h00);
    plan_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'h3F, 8'hFF);
    plan_word(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 8'hFF);
    plan_word(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 8'h00);
    plan_word(OP_LOOKUP, 32'hFFFF_FFFE, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h0000_0000, 6'd32, 8'h01);
    plan_word(OP_LOOKUP, 32'h0000_0000, 6'd5, 8'h77);
    plan_word(OP_INSERT, 32'hDEAD_BEEF, 6'd0, 8'h5A);
    plan_word(OP_LOOKUP, 32'h1234_5678, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'hA5A5_A5A5, 6'd63, 8'h33);
    plan_word(OP_LOOKUP, 32'hA5A5_A5A5, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h0A01_0000, 6'd16, 8'h09);
    plan_word(OP_INSERT, 32'h0A00_0000, 6'd8, 8'h07);
    plan_word(OP_LOOKUP, 32'h0A01_FFFF, 6'd0, 8'h00);
    plan_word(OP_LOOKUP, 32'h0A02_0304, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h0A00_0000, 6'd8, 8'h80);
    plan_word(OP_LOOKUP, 32'h0A02_0304, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h0A01_02FF, 6'd24, 8'h00);
    plan_word(OP_LOOKUP, 32'h0A01_0203, 6'd0, 8'h00);
    plan_word(OP_LOOKUP, 32'h0A01_FF00, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h8000_0000, 6'd1, 8'hAA);
    plan_word(OP_LOOKUP, 32'hC000_0000, 6'd0, 8'h00);
    plan_word(OP_INSERT, 32'h7FFF_FFFF, 6'd33, 8'h5C);

    // mixed traffic, nested prefixes and lookups that mostly hit
    for (int i = 0; i < 220; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        r = $urandom_range(0, 9);
        len = (r < 6) ? $urandom_range(0, 16) :
              (r < 9) ? $urandom_range(17, 32) : $urandom_range(33, 63);
        addr = $urandom_range(0, 1) ? $urandom() : addr_under();
        plan_word(OP_INSERT, addr, len, $urandom_range(0, 255));
      end else begin
        addr = ($urandom_range(0, 9) < 7) ? addr_under() : $urandom();
        plan_word(OP_LOOKUP, addr, $urandom_range(0, 63), $urandom_range(0, 255));
      end
    end

    // deep host routes until the node pool runs out
    for (int i = 0; i < 260; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(33, 63) : 6'd32;
        addr = ($urandom_range(0, 9) == 0) ? addr_under() : $urandom();
        plan_word(OP_INSERT, addr, len, $urandom_range(0, 255), i == 0);
      end else begin
        plan_word(OP_LOOKUP, addr_under(), $urandom_range(0, 63),
                  $urandom_range(0, 255), i == 0);
      end
    end

    // pool full: re-inserts still land, new paths mostly refused
    for (int i = 0; i < 100; i++) begin
      r = $urandom_range(0, 19);
      if (r < 4) begin
        pick = $urandom_range(0, known_addr.size() - 1);
        plan_word(OP_INSERT, known_addr[pick], known_len[pick],
                  $urandom_range(0, 255), i == 0);
      end else if (r < 7) begin
        plan_word(OP_INSERT, $urandom(), $urandom_range(0, 32),
                  $urandom_range(0, 255), i == 0);
      end else begin
        addr = ($urandom_range(0, 9) < 8) ? addr_under() : $urandom();
        plan_word(OP_LOOKUP, addr, $urandom_range(0, 63), $urandom_range(0, 255),
                  i == 0);
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (words_sent < words_planned) @(posedge clk);
    while (awaited_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("** binary_trie_prefix_lookup_unit: PASSED **");
    end else begin
      $display("** binary_trie_prefix_lookup_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/btpl_pkg.sv
hw/rtl/btpl_if.sv
hw/rtl/btpl_datapath.sv
hw/rtl/btpl_ctrl.sv
hw/rtl/binary_trie_prefix_lookup_unit.sv
hw/rtl/btpl_checker.sv
verif/binary_trie_prefix_lookup_unit_test.sv
